// ===== rtl/core/alir_pkg.sv =====
// Shared types and codes for the array list insert/remove block.
package alir_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT      = 2'd0,
		MODE_APPEND      = 2'd1,
		MODE_REMOVE      = 2'd2,
		MODE_REMOVE_LAST = 2'd3
	} alir_mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} alir_status_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_EXEC = 2'b10
	} alir_fsm_t;

	typedef struct packed {
		alir_mode_t         mode;
		logic [3:0]         position;
		logic signed [31:0] value;
	} alir_in_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		alir_status_t       status;
		logic [3:0]         count;
	} alir_out_t;

	typedef struct packed {
		logic load;
		logic exec;
	} alir_cmd_t;

endpackage

// ===== rtl/core/array_list_insert_remove.sv =====
// Array list of up to DEPTH signed 32-bit values with shifting insert and remove.
// Raise start with an operation on req while busy is low; it is taken at that clock
// edge. The operation executes in the next cycle, moving the entries from the chosen slot
// onward to their neighbors in parallel, and its result shows on result with done high for
// exactly one cycle after that; a new item may be started in the cycle that done is
// shown. The receiver cannot stall: take result whenever done is high. Stored entries
// come up undefined after reset; the count starts at zero, so only written entries are
// ever returned.
module array_list_insert_remove #(
	parameter int DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  alir_pkg::alir_in_t  req,
	output logic                done,
	output alir_pkg::alir_out_t result
);
	import alir_pkg::*;

	alir_cmd_t cmd;

	alir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	alir_dpath #(.DEPTH(DEPTH)) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.result (result)
	);

endmodule

// ===== rtl/core/alir_ctrl.sv =====
// Controller: sequences capture, execution and the result strobe.
module alir_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output alir_pkg::alir_cmd_t cmd
);
	import alir_pkg::*;

	alir_fsm_t state_q;
	alir_fsm_t state_d;
	logic      done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (start) state_d = FSM_EXEC;
			end
			FSM_EXEC: begin
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == FSM_EXEC);
		end
	end

	assign cmd.load = start && (state_q == FSM_IDLE);
	assign cmd.exec = (state_q == FSM_EXEC);
	assign busy     = (state_q == FSM_EXEC);
	assign done     = done_q;

endmodule

// ===== rtl/core/alir_dpath.sv =====
// Datapath: entry row with parallel shift, entry count and result register.
module alir_dpath #(
	parameter int DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  alir_pkg::alir_cmd_t cmd,
	input  alir_pkg::alir_in_t  req,
	output alir_pkg::alir_out_t result
);
	import alir_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 4) ? CW : 4;

	alir_in_t           req_q;
	logic [31:0]        entries_q [DEPTH];
	logic [31:0]        entries_d [DEPTH];
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	alir_out_t          result_q;
	alir_out_t          result_d;

	logic [CMPW-1:0]    cnt_ext;
	logic [CMPW-1:0]    pos_ext;
	logic               is_ins;
	logic               full;
	logic               empty;
	alir_status_t       status;
	logic [31:0]        rd_val;

	always_comb begin
		cnt_ext = CMPW'(count_q);
		unique case (req_q.mode)
			MODE_INSERT, MODE_REMOVE: pos_ext = CMPW'(req_q.position);
			MODE_APPEND:              pos_ext = cnt_ext;
			MODE_REMOVE_LAST:         pos_ext = (count_q == '0) ? '0 : cnt_ext - CMPW'(1);
			default:                  pos_ext = cnt_ext;
		endcase

		is_ins = (req_q.mode == MODE_INSERT) || (req_q.mode == MODE_APPEND);
		full   = (count_q == CW'(DEPTH));
		empty  = (count_q == '0);

		priority if (is_ins && full)             status = ST_FULL;
		else if (is_ins && (pos_ext > cnt_ext))  status = ST_BADPOS;
		else if (!is_ins && empty)               status = ST_EMPTY;
		else if (!is_ins && (pos_ext >= cnt_ext)) status = ST_BADPOS;
		else                                     status = ST_OK;

		rd_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (pos_ext == CMPW'(i)) rd_val = entries_q[i];
		end

		// shift the row in parallel around the chosen slot
		for (int i = 0; i < DEPTH; i++) entries_d[i] = entries_q[i];
		count_d = count_q;
		if (status == ST_OK) begin
			if (is_ins) begin
				for (int i = 1; i < DEPTH; i++) begin
					if (CMPW'(i) > pos_ext) entries_d[i] = entries_q[i-1];
				end
				for (int i = 0; i < DEPTH; i++) begin
					if (CMPW'(i) == pos_ext) entries_d[i] = req_q.value;
				end
				count_d = count_q + CW'(1);
			end else begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					if (CMPW'(i) >= pos_ext) entries_d[i] = entries_q[i+1];
				end
				count_d = count_q - CW'(1);
			end
		end

		result_d.removed_value = (!is_ins && (status == ST_OK)) ? rd_val : '0;
		result_d.status        = status;
		result_d.count         = 4'(count_d);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.exec) begin
			for (int i = 0; i < DEPTH; i++) entries_q[i] <= entries_d[i];
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	assign result = result_q;

endmodule

// ===== rtl/core/alir_checker.sv =====
// Port-level assertions for the array list block, bound to the top level.
module alir_checker #(
	parameter int DEPTH = 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input alir_pkg::alir_out_t result
);
	import alir_pkg::*;

	localparam logic [3:0] FULL_CNT = 4'(DEPTH);

	a_done_two_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("item did not complete two cycles after acceptance");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_error_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> (result.removed_value == '0))
		else $error("failed operation returned a value");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_FULL)) |-> (result.count == FULL_CNT))
		else $error("full status with count below depth");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_EMPTY)) |-> (result.count == 4'd0))
		else $error("empty status with nonzero count");

endmodule

bind array_list_insert_remove alir_checker #(.DEPTH(DEPTH)) u_alir_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== sim/tb_array_list_insert_remove.sv =====
// Testbench for the shifting array list: directed corner operations, then random phases.
module tb_array_list_insert_remove;
	timeunit 1ns;
	timeprecision 1ps;

	import alir_pkg::*;

	localparam int DEPTH = 8;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	alir_in_t  req;
	logic      done;
	alir_out_t result;

	array_list_insert_remove #(
		.DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.result(result)
	);

	// Shadow copy of the list; predicts one result per accepted item.
	class shadow_list;
		logic signed [31:0] store [DEPTH];
		int                 n_entries;
		alir_out_t          pending_results [$];
		int                 n_errors;

		function new();
			n_entries = 0;
			n_errors  = 0;
		endfunction

		task report(string msg);
			$display("%0t ERROR: %s", $time, msg);
			n_errors++;
		endtask

		function void note_op(alir_in_t op);
			alir_out_t r;
			int        p;
			r.removed_value = '0;
			r.status        = ST_OK;
			case (op.mode)
				MODE_INSERT, MODE_APPEND: begin
					p = (op.mode == MODE_APPEND) ? n_entries : int'(op.position);
					if (n_entries >= DEPTH)
						r.status = ST_FULL;
					else if (p > n_entries)
						r.status = ST_BADPOS;
					else begin
						for (int i = n_entries; i > p; i--)
							store[i] = store[i - 1];
						store[p] = op.value;
						n_entries++;
					end
				end
				default: begin
					if (op.mode == MODE_REMOVE_LAST)
						p = (n_entries == 0) ? 0 : n_entries - 1;
					else
						p = int'(op.position);
					if (n_entries == 0)
						r.status = ST_EMPTY;
					else if (p >= n_entries)
						r.status = ST_BADPOS;
					else begin
						r.removed_value = store[p];
						n_entries--;
						for (int i = p; i < n_entries; i++)
							store[i] = store[i + 1];
					end
				end
			endcase
			r.count = n_entries[3:0];
			pending_results.push_back(r);
		endfunction

		task check_result(alir_out_t got);
			alir_out_t exp_r;
			if (pending_results.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			exp_r = pending_results.pop_front();
			if (got.removed_value !== exp_r.removed_value)
				report($sformatf("removed_value %0d, want %0d",
					got.removed_value, exp_r.removed_value));
			if (got.status !== exp_r.status)
				report($sformatf("status %s, want %s", got.status.name(), exp_r.status.name()));
			if (got.count !== exp_r.count)
				report($sformatf("count %0d, want %0d", got.count, exp_r.count));
		endtask
	endclass

	shadow_list sb;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

	function automatic alir_in_t make_op(alir_mode_t m, logic [3:0] p, logic signed [31:0] v);
		alir_in_t op;
		op.mode     = m;
		op.position = p;
		op.value    = v;
		return op;
	endfunction

	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(99) >= 10)
			return $urandom;
		case ($urandom_range(3))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh0;
			default: return -32'sd1;
		endcase
	endfunction

	// Favor inserts while filling and removes while draining so both ends get hit.
	function automatic alir_in_t random_op(int n, bit filling);
		alir_mode_t m;
		logic [3:0] p;
		int         roll;
		roll = $urandom_range(99);
		if (filling)
			m = (roll < 40) ? MODE_INSERT : (roll < 70) ? MODE_APPEND :
				(roll < 85) ? MODE_REMOVE : MODE_REMOVE_LAST;
		else
			m = (roll < 40) ? MODE_REMOVE : (roll < 70) ? MODE_REMOVE_LAST :
				(roll < 85) ? MODE_INSERT : MODE_APPEND;
		if ($urandom_range(99) < 80)
			p = 4'($urandom_range(n));
		else
			p = 4'($urandom_range(15));
		return make_op(m, p, pick_value());
	endfunction

	task send_op(alir_in_t op, int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= op;
		do @(posedge clk); while (busy);
		sb.note_op(op);
	endtask

	initial begin
		int idle_pct [4];
		bit filling;
		int guard;
		sb       = new();
		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		idle_pct = '{0, 67, 0, 26};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list, bad positions, extremes, boundary inserts.
		send_op(make_op(MODE_REMOVE_LAST, 4'd0, 32'sd5), 0);
		send_op(make_op(MODE_REMOVE, 4'd15, 32'sd0), 0);
		send_op(make_op(MODE_INSERT, 4'd1, -32'sd1), 0);
		send_op(make_op(MODE_INSERT, 4'd0, 32'sh7fffffff), 0);
		send_op(make_op(MODE_APPEND, 4'd15, 32'sh80000000), 0);
		send_op(make_op(MODE_INSERT, 4'd1, 32'sd0), 0);
		send_op(make_op(MODE_INSERT, 4'd3, -32'sd1), 0);
		send_op(make_op(MODE_REMOVE, 4'd4, 32'sd0), 0);
		send_op(make_op(MODE_INSERT, 4'd15, 32'sd7), 0);
		repeat (4) send_op(make_op(MODE_APPEND, 4'($urandom), $urandom), 0);
		// Full list: full wins over a bad position.
		send_op(make_op(MODE_INSERT, 4'd0, 32'sd1), 0);
		send_op(make_op(MODE_APPEND, 4'd0, 32'sd2), 0);
		send_op(make_op(MODE_INSERT, 4'd15, 32'sd3), 0);
		send_op(make_op(MODE_REMOVE, 4'd7, 32'sd0), 0);
		send_op(make_op(MODE_REMOVE, 4'd0, 32'sd0), 0);
		send_op(make_op(MODE_REMOVE, 4'd2, 32'sd0), 0);
		send_op(make_op(MODE_REMOVE_LAST, 4'd9, 32'sd0), 0);
		send_op(make_op(MODE_REMOVE, 4'd15, 32'sd0), 0);
		repeat (3) send_op(make_op(MODE_REMOVE_LAST, 4'($urandom), 32'sd0), 0);
		send_op(make_op(MODE_REMOVE, 4'd0, -32'sd1), 0);

		filling = 1'b1;
		foreach (idle_pct[ph]) begin
			repeat (300) begin
				if (sb.n_entries >= DEPTH)
					filling = 1'b0;
				else if (sb.n_entries == 0)
					filling = 1'b1;
				else if ($urandom_range(99) < 3)
					filling = !filling;
				send_op(random_op(sb.n_entries, filling), idle_pct[ph]);
			end
		end
		start <= 1'b0;

		guard = 0;
		while (sb.pending_results.size() > 0 && guard < 100) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (sb.pending_results.size() > 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

		if (sb.n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/alir_pkg.sv
rtl/core/alir_ctrl.sv
rtl/core/alir_dpath.sv
rtl/core/array_list_insert_remove.sv
rtl/core/alir_checker.sv
sim/tb_array_list_insert_remove.sv
